/* hdl/pbo_pkg.sv */
package pbo_pkg;

  localparam int PhaseW   = 32;
  localparam int SampleW  = 24;
  localparam int SineDepth = 1024;
  localparam int SineAw   = 10;
  localparam int IncW     = 31;
  localparam int WaveW    = 2;
  localparam int IntegW   = 34;
  localparam int AccW     = 36;
  localparam int ProdW    = 66;

  localparam logic [WaveW-1:0] WAVE_SINE   = 2'd0;
  localparam logic [WaveW-1:0] WAVE_SAW    = 2'd1;
  localparam logic [WaveW-1:0] WAVE_SQUARE = 2'd2;
  localparam logic [WaveW-1:0] WAVE_TRI    = 2'd3;

  localparam logic CFG_IDX_WAVE = 1'b0;
  localparam logic CFG_IDX_INC  = 1'b1;

  localparam logic [31:0] LeakQ32   = 32'd2147484;
  localparam logic [63:0] PihalfQ30 = 64'd1686629713;
  localparam logic [SampleW-1:0] OutMax = 24'h7F_FFFF;

  typedef logic [SampleW-1:0] sine_rom_t [SineDepth];

  // quarter-wave sine, taylor series in q30, rounded to q23
  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint sum;
    for (int i = 0; i < SineDepth; i++) begin
      x = (64'(i) * PihalfQ30) / 64'(SineDepth);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) + 64'd64) >> 7;
      if (v > 64'(OutMax)) begin
        v = 64'(OutMax);
      end
      rom[i] = v[SampleW-1:0];
    end
    return rom;
  endfunction

endpackage

/* hdl/pbo_req_if.sv */
interface pbo_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] start_phase;

  modport source (output valid, output req_type, output start_phase, input ready);
  modport sink (input valid, input req_type, input start_phase, output ready);
endinterface

/* hdl/pbo_smp_if.sv */
interface pbo_smp_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* hdl/polyblep_oscillator_core.sv */
// Band-limited oscillator: each tick transfer on req gives one Q1.23 sample on smp, a
// phase-reset transfer loads the phase, clears the triangle integrator and gives no sample.
// The block takes one request at a time. A sine tick uses a registered table read. For saw,
// square and triangle, each polyBLEP edge correction runs a 32-step restoring divider, one
// quotient bit per cycle, followed by a pass through the single shared 34x32 multiplier;
// triangle uses the multiplier twice more. Edges with no correction skip the divider and
// multiplier. Configure waveform (index 0) and phase increment (index 1) only while idle.
module polyblep_oscillator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  pbo_req_if.sink     req,
  pbo_smp_if.source   smp
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SINE_RD  = 4'd1;
  localparam logic [3:0] S_SINE_OUT = 4'd2;
  localparam logic [3:0] S_EDGE     = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_SQ       = 4'd5;
  localparam logic [3:0] S_SQACC    = 4'd6;
  localparam logic [3:0] S_NEXT     = 4'd7;
  localparam logic [3:0] S_TRI1     = 4'd8;
  localparam logic [3:0] S_TRI2     = 4'd9;
  localparam logic [3:0] S_TRI3     = 4'd10;
  localparam logic [3:0] S_TRI4     = 4'd11;
  localparam logic [3:0] S_OUT      = 4'd12;

  localparam pbo_pkg::sine_rom_t SINE_ROM = pbo_pkg::build_sine();

  logic [3:0]                          state_q, state_d;
  logic [pbo_pkg::WaveW-1:0]           wave_q;
  logic [pbo_pkg::IncW-1:0]            inc_q;
  logic [pbo_pkg::PhaseW-1:0]          phase_q;
  logic signed [pbo_pkg::IntegW-1:0]   integ_q;
  logic [pbo_pkg::PhaseW-1:0]          p_q;
  logic signed [pbo_pkg::AccW-1:0]     acc_q;
  logic                                edge_sel_q;
  logic                                neg_q;
  logic [31:0]                         rem_q;
  logic [31:0]                         quo_q;
  logic [4:0]                          cnt_q;
  logic [pbo_pkg::ProdW-1:0]           prod_q;
  logic [pbo_pkg::SampleW-1:0]         rom_q;
  logic                                out_valid_q;
  logic signed [pbo_pkg::SampleW-1:0]  sample_q;

  logic                                req_xfer, out_slot;
  logic [33:0]                         mul_a;
  logic [31:0]                         mul_b;
  logic [31:0]                         pe, pe_hi, u32, rem_nx;
  logic                                is_lo, is_hi, div_ge, sub_edge;
  logic [32:0]                         div_t, sqv;
  logic [pbo_pkg::AccW-1:0]            acc_mag;
  logic signed [36:0]                  tri_sum, tri_t;
  logic signed [pbo_pkg::IntegW-1:0]   tri_sat;
  logic [33:0]                         leak_m, leak_v;
  logic signed [pbo_pkg::AccW-1:0]     out_clamp;
  logic [pbo_pkg::AccW-1:0]            out_u;
  logic [26:0]                         out_r;
  logic [pbo_pkg::SampleW-1:0]         out_code, sine_v;
  logic [pbo_pkg::SineAw-1:0]          sine_i, sine_addr;

  assign req.ready  = (state_q == S_IDLE);
  assign req_xfer   = req.valid && req.ready;
  assign smp.valid  = out_valid_q;
  assign smp.sample = sample_q;
  assign out_slot   = !out_valid_q || smp.ready;

  // edge selection and divider
  assign pe       = edge_sel_q ? (p_q + 32'h8000_0000) : p_q;
  assign is_lo    = pe < {1'b0, inc_q};
  assign is_hi    = {1'b0, pe} > (33'h1_0000_0000 - {2'b0, inc_q});
  assign pe_hi    = pe + {1'b0, inc_q};
  assign div_t    = {rem_q, 1'b0};
  assign div_ge   = div_t >= {2'b0, inc_q};
  assign rem_nx   = div_ge ? 32'(div_t - {2'b0, inc_q}) : div_t[31:0];
  assign u32      = neg_q ? (32'd0 - quo_q) : quo_q;
  assign sqv      = (neg_q && quo_q == 32'd0) ? 33'h1_0000_0000 : {1'b0, prod_q[63:32]};
  assign sub_edge = (wave_q == pbo_pkg::WAVE_SAW) || edge_sel_q;

  // triangle integrator
  assign acc_mag  = acc_q[pbo_pkg::AccW-1] ? 36'(-acc_q) : 36'(acc_q);
  assign tri_t    = $signed({2'b0, prod_q[62:28]});
  assign tri_sum  = acc_q[pbo_pkg::AccW-1] ? (37'(integ_q) - tri_t) : (37'(integ_q) + tri_t);
  assign tri_sat  = (tri_sum > 37'sh1_FFFF_FFFF) ? 34'sh1_FFFF_FFFF :
                    (tri_sum < -37'sh2_0000_0000) ? -34'sh2_0000_0000 : 34'(tri_sum);
  assign leak_m   = acc_mag[33:0];
  assign leak_v   = leak_m - prod_q[65:32];

  // q32 to output code
  assign out_clamp = (acc_q > 36'sh1_0000_0000) ? 36'sh1_0000_0000 :
                     (acc_q < -36'sh1_0000_0000) ? -36'sh1_0000_0000 : acc_q;
  assign out_u     = 36'(out_clamp) + 36'h1_0000_0000 + 36'd256;
  assign out_r     = out_u[35:9];
  assign out_code  = (out_r >= 27'h100_0000) ? pbo_pkg::OutMax : (out_r[23:0] ^ 24'h80_0000);

  // sine quadrant folding
  assign sine_i    = p_q[29:20];
  assign sine_addr = p_q[30] ? (10'd0 - sine_i) : sine_i;
  assign sine_v    = (p_q[30] && sine_i == 10'd0) ? pbo_pkg::OutMax : rom_q;

  always_comb begin
    mul_a = 34'(u32);
    mul_b = u32;
    case (state_q)
      S_TRI1: begin
        mul_a = 34'(acc_mag >> 2);
        mul_b = {1'b0, inc_q};
      end
      S_TRI3: begin
        mul_a = leak_m;
        mul_b = pbo_pkg::LeakQ32;
      end
      default: begin
        mul_a = 34'(u32);
        mul_b = u32;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_xfer && !req.req_type) begin
          state_d = (wave_q == pbo_pkg::WAVE_SINE) ? S_SINE_RD : S_EDGE;
        end
      end
      S_SINE_RD:  state_d = S_SINE_OUT;
      S_SINE_OUT: if (out_slot) state_d = S_IDLE;
      S_EDGE: begin
        if (inc_q != '0 && (is_lo || is_hi)) begin
          state_d = S_DIV;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_DIV:   if (cnt_q == 5'd31) state_d = S_SQ;
      S_SQ:    state_d = S_SQACC;
      S_SQACC: state_d = S_NEXT;
      S_NEXT: begin
        if (!edge_sel_q && wave_q != pbo_pkg::WAVE_SAW) begin
          state_d = S_EDGE;
        end else if (wave_q == pbo_pkg::WAVE_TRI) begin
          state_d = S_TRI1;
        end else begin
          state_d = S_OUT;
        end
      end
      S_TRI1: state_d = S_TRI2;
      S_TRI2: state_d = S_TRI3;
      S_TRI3: state_d = S_TRI4;
      S_TRI4: state_d = S_OUT;
      S_OUT:  if (out_slot) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == S_SINE_RD) begin
      rom_q <= SINE_ROM[sine_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wave_q      <= pbo_pkg::WAVE_SINE;
      inc_q       <= '0;
      phase_q     <= '0;
      integ_q     <= '0;
      p_q         <= '0;
      acc_q       <= '0;
      edge_sel_q  <= 1'b0;
      neg_q       <= 1'b0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pbo_pkg::CFG_IDX_WAVE: wave_q <= cfg_wdata_i[1:0];
          pbo_pkg::CFG_IDX_INC:  inc_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && smp.ready && state_q != S_OUT && state_q != S_SINE_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_xfer) begin
            if (req.req_type) begin
              phase_q <= req.start_phase;
              integ_q <= '0;
            end else begin
              p_q        <= phase_q;
              phase_q    <= phase_q + {1'b0, inc_q};
              edge_sel_q <= 1'b0;
              if (wave_q == pbo_pkg::WAVE_SAW) begin
                acc_q <= $signed({3'b0, phase_q, 1'b0}) - 36'sh1_0000_0000;
              end else begin
                acc_q <= phase_q[31] ? -36'sh1_0000_0000 : 36'sh1_0000_0000;
              end
            end
          end
        end
        S_SINE_OUT: begin
          if (out_slot) begin
            out_valid_q <= 1'b1;
            sample_q    <= p_q[31] ? -$signed(sine_v) : $signed(sine_v);
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        S_EDGE: begin
          neg_q <= is_lo;
          rem_q <= is_lo ? pe : pe_hi;
          quo_q <= '0;
          cnt_q <= '0;
        end
        S_DIV: begin
          rem_q <= rem_nx;
          quo_q <= {quo_q[30:0], div_ge};
          cnt_q <= cnt_q + 5'd1;
        end
        S_SQACC: begin
          if (neg_q == sub_edge) begin
            acc_q <= acc_q + $signed(36'(sqv));
          end else begin
            acc_q <= acc_q - $signed(36'(sqv));
          end
        end
        S_NEXT: edge_sel_q <= 1'b1;
        S_TRI2: acc_q <= 36'(tri_sat);
        S_TRI4: begin
          integ_q <= acc_q[pbo_pkg::AccW-1] ? -$signed(leak_v) : $signed(leak_v);
          acc_q   <= acc_q[pbo_pkg::AccW-1] ? -$signed(36'(leak_v)) : $signed(36'(leak_v));
        end
        S_OUT: begin
          if (out_slot) begin
            out_valid_q <= 1'b1;
            sample_q    <= out_code;
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == 5'd31) |=> (state_q == S_SQ))
    else $error("divider did not end after 32 steps");

  a_phase_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && req.req_type) |=> (integ_q == '0 && state_q == S_IDLE))
    else $error("phase reset left integrator or sequencer busy");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && !req.req_type) |=> !req.ready)
    else $error("tick transfer did not start the sequencer");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !smp.ready) |=> $stable(sample_q))
    else $error("pending sample overwritten");

endmodule

/* test/polyblep_oscillator_core_tb.sv */
module polyblep_oscillator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class sample_scoreboard;
    logic [1:0]  wave;
    logic [30:0] inc;
    logic [31:0] phase;
    longint      integ;
    logic [23:0] rom [pbo_pkg::SineDepth];
    logic [23:0] pending [$];
    int          errors;

    function void init();
      logic [63:0] x, x2, term, v;
      longint sum;
      for (int i = 0; i < pbo_pkg::SineDepth; i++) begin
        x = (64'(i) * 64'd1686629713) / 64'(pbo_pkg::SineDepth);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 8; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        v = (64'(sum) + 64'd64) >> 7;
        if (v > 64'h7fffff) v = 64'h7fffff;
        rom[i] = v[23:0];
      end
      wave = pbo_pkg::WAVE_SINE;
      inc = '0;
      phase = '0;
      integ = 0;
      errors = 0;
    endfunction

    function logic [31:0] qdiv(logic [63:0] num, logic [63:0] den);
      logic [31:0] q;
      q = '0;
      for (int k = 0; k < 32; k++) begin
        num = num << 1;
        q = q << 1;
        if (num >= den) begin
          num = num - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function longint squared(logic [63:0] u);
      logic [127:0] w;
      if (u >= 64'h1_0000_0000) return 64'sh1_0000_0000;
      w = u * u;
      return longint'(w >> 32);
    endfunction

    function longint blep(logic [63:0] p, logic [63:0] d);
      if (d == 0) return 0;
      if (p < d) return -squared(64'h1_0000_0000 - qdiv(p, d));
      if (p > 64'h1_0000_0000 - d) return squared(qdiv(p + d - 64'h1_0000_0000, d));
      return 0;
    endfunction

    function longint square_wave(logic [63:0] p, logic [63:0] d);
      longint s;
      s = (p < 64'h8000_0000) ? 64'sh1_0000_0000 : -64'sh1_0000_0000;
      s += blep(p, d);
      s -= blep((p + 64'h8000_0000) & 64'hffff_ffff, d);
      return s;
    endfunction

    function logic [23:0] to_sample(longint v);
      logic [63:0] u;
      longint r;
      if (v > 64'sh1_0000_0000) v = 64'sh1_0000_0000;
      if (v < -64'sh1_0000_0000) v = -64'sh1_0000_0000;
      u = 64'(v + 64'sh1_0000_0000) + 64'd256;
      r = longint'(u >> 9) - 64'sh80_0000;
      if (r > 64'sh7f_ffff) r = 64'sh7f_ffff;
      return r[23:0];
    endfunction

    function logic [23:0] sine(logic [31:0] p);
      logic [1:0] quad;
      logic [9:0] i;
      longint v;
      quad = p[31:30];
      i = p[29:20];
      if (quad[0]) v = (i == 0) ? 64'sh7f_ffff : longint'(rom[pbo_pkg::SineDepth - i]);
      else v = longint'(rom[i]);
      if (quad[1]) v = -v;
      return v[23:0];
    endfunction

    function void note_request(logic rtype, logic [31:0] start);
      logic [63:0] p, d, mag;
      longint sq, t, s, m, dec;
      logic [23:0] res;
      p = 64'(phase);
      d = 64'(inc);
      if (rtype) begin
        phase = start;
        integ = 0;
        return;
      end
      case (wave)
        pbo_pkg::WAVE_SINE: res = sine(phase);
        pbo_pkg::WAVE_SAW: res = to_sample(longint'(2 * p) - 64'sh1_0000_0000 - blep(p, d));
        pbo_pkg::WAVE_SQUARE: res = to_sample(square_wave(p, d));
        default: begin
          sq = square_wave(p, d);
          mag = 64'(sq < 0 ? -sq : sq) >> 2;
          t = longint'((mag * d) >> 28);
          s = integ + (sq < 0 ? -t : t);
          if (s > 64'sh1_ffff_ffff) s = 64'sh1_ffff_ffff;
          if (s < -64'sh2_0000_0000) s = -64'sh2_0000_0000;
          m = s < 0 ? -s : s;
          dec = longint'((64'(m) * 64'd2147484) >> 32);
          integ = (s < 0) ? -(m - dec) : (m - dec);
          res = to_sample(integ);
        end
      endcase
      phase = 32'(p + d);
      pending.push_back(res);
    endfunction

    function void check_sample(logic [23:0] got);
      logic [23:0] exp_s;
      if (pending.size() == 0) begin
        $display("%0t unexpected sample %0d", $time, $signed(got));
        errors++;
        return;
      end
      exp_s = pending.pop_front();
      if (exp_s !== got) begin
        $display("%0t sample mismatch: expected %0d actual %0d", $time,
                 $signed(exp_s), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [30:0] cfg_wdata_i;
  int          hold_cycles;

  pbo_req_if req ();
  pbo_smp_if smp ();

  polyblep_oscillator_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req.sink),
    .smp        (smp.source)
  );

  sample_scoreboard sb;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  function int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, long hold when requested
  always @(posedge clk_i) begin
    if (rst_ni && smp.valid && smp.ready) sb.check_sample(smp.sample);
  end

  initial begin
    int n;
    smp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        smp.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      n = gap_len();
      if (n > 0) begin
        smp.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      smp.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic write_reg(logic idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pbo_pkg::CFG_IDX_WAVE) sb.wave = val[1:0];
    else sb.inc = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send(logic rtype, logic [31:0] start, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.req_type <= rtype;
    req.start_phase <= start;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(rtype, start);
  endtask

  task automatic idle_req();
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function logic [30:0] pick_inc();
    case ($urandom_range(0, 7))
      0: return 31'd0;
      1: return 31'd1932735283;
      2: return 31'h7fffffff;
      3: return 31'($urandom_range(1, 1000));
      4: return 31'($urandom_range(1000, 4000000));
      default: return 31'($urandom_range(4000000, 1932735283));
    endcase
  endfunction

  initial begin
    logic [30:0] incs [6];
    sb = new();
    sb.init();
    hold_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pbo_pkg::CFG_IDX_WAVE;
    cfg_wdata_i = '0;
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.start_phase = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each waveform over edge phases and increment extremes
    incs = '{31'd0, 31'd1932735283, 31'h7fffffff, 31'd1, 31'h0400_0000, 31'h2000_0000};
    for (int w = 0; w < 4; w++) begin
      write_reg(pbo_pkg::CFG_IDX_WAVE, 31'(w));
      for (int k = 0; k < 6; k++) begin
        write_reg(pbo_pkg::CFG_IDX_INC, incs[k]);
        send(1'b1, (k % 2) ? 32'hffff_ffff : 32'h0, 1'b0);
        send(1'b0, 32'hffff_ffff, 1'b0);
        send(1'b0, 32'h0, 1'b0);
        send(1'b1, 32'h4000_0000, 1'b0);
        send(1'b0, '0, 1'b0);
        send(1'b1, 32'h7fff_ffff, 1'b0);
        send(1'b0, '0, 1'b0);
        idle_req();
        drain();
      end
    end

    // long receiver hold while requests keep coming
    write_reg(pbo_pkg::CFG_IDX_WAVE, 31'(pbo_pkg::WAVE_SINE));
    write_reg(pbo_pkg::CFG_IDX_INC, 31'h0123_4567);
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) send(1'b0, 32'($urandom), 1'b0);
    idle_req();
    drain();

    // random phases, mostly ticks
    for (int ph = 0; ph < 27; ph++) begin
      write_reg(pbo_pkg::CFG_IDX_WAVE, 31'($urandom_range(0, 3)));
      write_reg(pbo_pkg::CFG_IDX_INC, pick_inc());
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 15) == 0) send(1'b1, 32'($urandom), 1'b1);
        else send(1'b0, 32'($urandom), 1'b1);
      end
      idle_req();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pbo_pkg.sv
hdl/pbo_req_if.sv
hdl/pbo_smp_if.sv
hdl/polyblep_oscillator_core.sv
test/polyblep_oscillator_core_tb.sv
